[rtl/hex_bytecode_image_parser_defines.svh]
// assertion macros shared by the hex bytecode image parser rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef HEX_BYTECODE_IMAGE_PARSER_DEFINES_SVH
`define HEX_BYTECODE_IMAGE_PARSER_DEFINES_SVH

// same-cycle implication, off during reset
`define HBIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define HBIP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hbip_pkg.sv]
// types and constants of the hex bytecode image parser
// no dependencies
package hbip_pkg;

  localparam logic [31:0] MagicWord   = 32'hC0C0FFEE;
  localparam logic [7:0]  CharHash    = 8'h23;
  localparam logic [7:0]  CharNewline = 8'h0A;
  localparam logic [7:0]  CharSpace   = 8'h20;

  // lexer phase, code 3 unused and treated as between bytes
  typedef enum logic [1:0] {
    PH_BETWEEN = 2'd0,
    PH_COMMENT = 2'd1,
    PH_HIGH    = 2'd2
  } phase_e;

  // position in the image layout
  typedef enum logic [3:0] {
    ST_VERSION    = 4'd0,
    ST_INT_COUNT  = 4'd1,
    ST_INT        = 4'd2,
    ST_STR_COUNT  = 4'd3,
    ST_STR_BYTE   = 4'd4,
    ST_FN_COUNT   = 4'd5,
    ST_ARGS       = 4'd6,
    ST_VARS       = 4'd7,
    ST_CODE_LEN   = 4'd8,
    ST_CODE_BYTE  = 4'd9,
    ST_NAT_COUNT  = 4'd10,
    ST_NAT_ARGS   = 4'd11,
    ST_NAT_INDEX  = 4'd12,
    ST_MAGIC      = 4'd15
  } stage_e;

  typedef enum logic [3:0] {
    KIND_VERSION    = 4'd0,
    KIND_INT_COUNT  = 4'd1,
    KIND_INT        = 4'd2,
    KIND_STR_COUNT  = 4'd3,
    KIND_STR_BYTE   = 4'd4,
    KIND_FN_COUNT   = 4'd5,
    KIND_ARGS       = 4'd6,
    KIND_VARS       = 4'd7,
    KIND_CODE_LEN   = 4'd8,
    KIND_CODE_BYTE  = 4'd9,
    KIND_NAT_COUNT  = 4'd10,
    KIND_NAT_ARGS   = 4'd11,
    KIND_NAT_INDEX  = 4'd12,
    KIND_ERROR      = 4'd13
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_BAD_HEX     = 3'd1,
    ERR_EOF_DIGIT   = 3'd2,
    ERR_BAD_SECOND  = 3'd3,
    ERR_PREMATURE   = 3'd4,
    ERR_BAD_MAGIC   = 3'd5
  } err_e;

  // what the lexer hands to the field assembler
  typedef enum logic [1:0] {
    TOK_NOP  = 2'd0,
    TOK_BYTE = 2'd1,
    TOK_ERR  = 2'd2
  } tok_kind_e;

  typedef struct packed {
    logic      sof;    // restart before this token
    tok_kind_e kind;
    logic [7:0] data;  // byte value, or error code in the low bits
  } token_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [15:0] entry;
    logic [15:0] func;
    err_e        err;
    logic        last;
  } result_t;

endpackage

[rtl/hbip_front.sv]
// character lexer: white space, comments, hex digit pairs
// depends on hbip_pkg
module hbip_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        char_code_i,
  input  logic              end_of_file_i,
  input  logic              start_of_file_i,
  output hbip_pkg::token_t  token_o
);

  hbip_pkg::phase_e phase_q, phase_d, phase_eff;
  logic [3:0] high_nibble_q, high_nibble_d;
  logic [4:0] hex;
  logic       blank;

  // bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  assign hex       = hex_decode(char_code_i);
  assign blank     = (char_code_i == hbip_pkg::CharSpace) ||
                     (char_code_i >= 8'h09 && char_code_i <= 8'h0D);
  assign phase_eff = start_of_file_i ? hbip_pkg::PH_BETWEEN : phase_q;

  // next state
  always_comb begin
    phase_d       = phase_q;
    high_nibble_d = high_nibble_q;
    if (accept_i && !end_of_file_i) begin
      case (phase_eff)
        hbip_pkg::PH_COMMENT: begin
          phase_d = (char_code_i == hbip_pkg::CharNewline) ? hbip_pkg::PH_BETWEEN
                                                          : hbip_pkg::PH_COMMENT;
        end
        hbip_pkg::PH_HIGH: begin
          phase_d = hbip_pkg::PH_BETWEEN;
        end
        default: begin
          if (char_code_i == hbip_pkg::CharHash) begin
            phase_d = hbip_pkg::PH_COMMENT;
          end else if (!blank && hex[4]) begin
            phase_d       = hbip_pkg::PH_HIGH;
            high_nibble_d = hex[3:0];
          end else begin
            phase_d = hbip_pkg::PH_BETWEEN;
          end
        end
      endcase
    end else if (accept_i) begin
      phase_d = phase_eff;
    end
  end

  // token for the accepted item
  always_comb begin
    token_o.sof  = start_of_file_i;
    token_o.kind = hbip_pkg::TOK_NOP;
    token_o.data = 8'd0;
    if (end_of_file_i) begin
      token_o.kind = hbip_pkg::TOK_ERR;
      token_o.data = {5'd0, (phase_eff == hbip_pkg::PH_HIGH) ? hbip_pkg::ERR_EOF_DIGIT
                                                             : hbip_pkg::ERR_PREMATURE};
    end else begin
      case (phase_eff)
        hbip_pkg::PH_COMMENT: begin
          token_o.kind = hbip_pkg::TOK_NOP;
        end
        hbip_pkg::PH_HIGH: begin
          if (hex[4]) begin
            token_o.kind = hbip_pkg::TOK_BYTE;
            token_o.data = {high_nibble_q, hex[3:0]};
          end else begin
            token_o.kind = hbip_pkg::TOK_ERR;
            token_o.data = {5'd0, hbip_pkg::ERR_BAD_SECOND};
          end
        end
        default: begin
          if (char_code_i != hbip_pkg::CharHash && !blank && !hex[4]) begin
            token_o.kind = hbip_pkg::TOK_ERR;
            token_o.data = {5'd0, hbip_pkg::ERR_BAD_HEX};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= hbip_pkg::PH_BETWEEN;
      high_nibble_q <= 4'd0;
    end else begin
      phase_q       <= phase_d;
      high_nibble_q <= high_nibble_d;
    end
  end

endmodule

[rtl/hbip_fifo.sv]
// token queue between lexer and field assembler
// depends on hbip_pkg and the assertion macro header
`include "hex_bytecode_image_parser_defines.svh"

module hbip_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hbip_pkg::token_t data_i,
  input  logic             pop_i,
  output hbip_pkg::token_t data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hbip_pkg::token_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `HBIP_ASSERT_IMP(a_no_push_full, push_i, !full_o, "push into full token queue")
  `HBIP_ASSERT_IMP(a_no_pop_empty, pop_i, !empty_o, "pop from empty token queue")
  `HBIP_ASSERT_NXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + CntW'(1),
                   "token count lost a push")

endmodule

[rtl/hbip_back.sv]
// field assembler: joins bytes into image fields and registers results
// depends on hbip_pkg and the assertion macro header
`include "hex_bytecode_image_parser_defines.svh"

module hbip_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hbip_pkg::token_t  token_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hbip_pkg::result_t out_o
);

  hbip_pkg::stage_e stage_q, stage_d, stage_eff;
  logic [1:0]  bif_q, bif_d, bif_eff;
  logic [31:0] acc_q, acc_d, acc_eff, acc_n;
  logic [15:0] pool_rem_q, pool_rem_d, pool_rem_eff, pool_rem_dec;
  logic [15:0] pool_pos_q, pool_pos_d, pool_pos_eff, pool_pos_inc;
  logic [15:0] fn_rem_q, fn_rem_d, fn_rem_eff, fn_rem_dec;
  logic [15:0] fn_pos_q, fn_pos_d, fn_pos_eff;
  logic [15:0] code_rem_q, code_rem_d, code_rem_eff, code_rem_dec;
  logic        halted_q, halted_d, halted_eff;
  logic        field_done, live_byte;
  logic [15:0] v16;

  logic              out_valid_q;
  hbip_pkg::result_t out_q, res;
  logic              res_valid;

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  // a restart token sees the reset state
  assign stage_eff    = token_i.sof ? hbip_pkg::ST_MAGIC : stage_q;
  assign bif_eff      = token_i.sof ? 2'd0 : bif_q;
  assign acc_eff      = token_i.sof ? 32'd0 : acc_q;
  assign pool_rem_eff = token_i.sof ? 16'd0 : pool_rem_q;
  assign pool_pos_eff = token_i.sof ? 16'd0 : pool_pos_q;
  assign fn_rem_eff   = token_i.sof ? 16'd0 : fn_rem_q;
  assign fn_pos_eff   = token_i.sof ? 16'd0 : fn_pos_q;
  assign code_rem_eff = token_i.sof ? 16'd0 : code_rem_q;
  assign halted_eff   = token_i.sof ? 1'b0 : halted_q;

  assign acc_n        = {acc_eff[23:0], token_i.data};
  assign v16          = acc_n[15:0];
  assign pool_rem_dec = pool_rem_eff - 16'd1;
  assign pool_pos_inc = pool_pos_eff + 16'd1;
  assign fn_rem_dec   = fn_rem_eff - 16'd1;
  assign code_rem_dec = code_rem_eff - 16'd1;
  assign live_byte    = pop_o && !halted_eff && (token_i.kind == hbip_pkg::TOK_BYTE);

  always_comb begin
    case (stage_eff)
      hbip_pkg::ST_MAGIC, hbip_pkg::ST_INT:          field_done = (bif_eff == 2'd3);
      hbip_pkg::ST_STR_BYTE, hbip_pkg::ST_CODE_BYTE: field_done = 1'b1;
      default:                                       field_done = (bif_eff == 2'd1);
    endcase
  end

  // next state
  always_comb begin
    stage_d    = stage_q;
    bif_d      = bif_q;
    acc_d      = acc_q;
    pool_rem_d = pool_rem_q;
    pool_pos_d = pool_pos_q;
    fn_rem_d   = fn_rem_q;
    fn_pos_d   = fn_pos_q;
    code_rem_d = code_rem_q;
    halted_d   = halted_q;
    if (pop_o) begin
      stage_d    = stage_eff;
      bif_d      = bif_eff;
      acc_d      = acc_eff;
      pool_rem_d = pool_rem_eff;
      pool_pos_d = pool_pos_eff;
      fn_rem_d   = fn_rem_eff;
      fn_pos_d   = fn_pos_eff;
      code_rem_d = code_rem_eff;
      halted_d   = halted_eff;
      if (!halted_eff && token_i.kind == hbip_pkg::TOK_ERR) begin
        halted_d = 1'b1;
      end
    end
    if (live_byte && !field_done) begin
      bif_d = bif_eff + 2'd1;
      acc_d = acc_n;
    end else if (live_byte) begin
      bif_d = 2'd0;
      acc_d = 32'd0;
      case (stage_eff)
        hbip_pkg::ST_MAGIC: begin
          if (acc_n != hbip_pkg::MagicWord) begin
            halted_d = 1'b1;
          end else begin
            stage_d = hbip_pkg::ST_VERSION;
          end
        end
        hbip_pkg::ST_VERSION: stage_d = hbip_pkg::ST_INT_COUNT;
        hbip_pkg::ST_INT_COUNT: begin
          pool_rem_d = v16;
          pool_pos_d = 16'd0;
          stage_d    = (v16 == 16'd0) ? hbip_pkg::ST_STR_COUNT : hbip_pkg::ST_INT;
        end
        hbip_pkg::ST_STR_COUNT: begin
          pool_rem_d = v16;
          pool_pos_d = 16'd0;
          stage_d    = (v16 == 16'd0) ? hbip_pkg::ST_FN_COUNT : hbip_pkg::ST_STR_BYTE;
        end
        hbip_pkg::ST_INT: begin
          pool_pos_d = pool_pos_inc;
          pool_rem_d = pool_rem_dec;
          if (pool_rem_dec == 16'd0) stage_d = hbip_pkg::ST_STR_COUNT;
        end
        hbip_pkg::ST_STR_BYTE: begin
          pool_pos_d = pool_pos_inc;
          pool_rem_d = pool_rem_dec;
          if (pool_rem_dec == 16'd0) stage_d = hbip_pkg::ST_FN_COUNT;
        end
        hbip_pkg::ST_FN_COUNT: begin
          fn_rem_d = v16;
          fn_pos_d = 16'd0;
          stage_d  = (v16 == 16'd0) ? hbip_pkg::ST_NAT_COUNT : hbip_pkg::ST_ARGS;
        end
        hbip_pkg::ST_ARGS: stage_d = hbip_pkg::ST_VARS;
        hbip_pkg::ST_VARS: stage_d = hbip_pkg::ST_CODE_LEN;
        hbip_pkg::ST_CODE_LEN: begin
          code_rem_d = v16;
          pool_pos_d = 16'd0;
          if (v16 == 16'd0) begin
            // empty code body closes the function at once
            fn_pos_d = fn_pos_eff + 16'd1;
            fn_rem_d = fn_rem_dec;
            stage_d  = (fn_rem_dec == 16'd0) ? hbip_pkg::ST_NAT_COUNT : hbip_pkg::ST_ARGS;
          end else begin
            stage_d = hbip_pkg::ST_CODE_BYTE;
          end
        end
        hbip_pkg::ST_CODE_BYTE: begin
          pool_pos_d = pool_pos_inc;
          code_rem_d = code_rem_dec;
          if (code_rem_dec == 16'd0) begin
            fn_pos_d = fn_pos_eff + 16'd1;
            fn_rem_d = fn_rem_dec;
            stage_d  = (fn_rem_dec == 16'd0) ? hbip_pkg::ST_NAT_COUNT : hbip_pkg::ST_ARGS;
          end
        end
        hbip_pkg::ST_NAT_COUNT: begin
          pool_rem_d = v16;
          pool_pos_d = 16'd0;
          if (v16 == 16'd0) begin
            halted_d = 1'b1;
          end else begin
            stage_d = hbip_pkg::ST_NAT_ARGS;
          end
        end
        hbip_pkg::ST_NAT_ARGS: stage_d = hbip_pkg::ST_NAT_INDEX;
        hbip_pkg::ST_NAT_INDEX: begin
          pool_pos_d = pool_pos_inc;
          pool_rem_d = pool_rem_dec;
          if (pool_rem_dec == 16'd0) begin
            halted_d = 1'b1;
          end else begin
            stage_d = hbip_pkg::ST_NAT_ARGS;
          end
        end
        default: halted_d = 1'b1;
      endcase
    end
  end

  // result for the popped token
  always_comb begin
    res_valid = 1'b0;
    res.kind  = hbip_pkg::KIND_ERROR;
    res.value = acc_n;
    res.entry = 16'd0;
    res.func  = 16'd0;
    res.err   = hbip_pkg::ERR_NONE;
    res.last  = 1'b0;
    if (pop_o && !halted_eff && token_i.kind == hbip_pkg::TOK_ERR) begin
      res_valid = 1'b1;
      res.value = 32'd0;
      res.err   = hbip_pkg::err_e'(token_i.data[2:0]);
      res.last  = 1'b1;
    end else if (live_byte && field_done) begin
      res_valid = 1'b1;
      case (stage_eff)
        hbip_pkg::ST_MAGIC: begin
          res_valid = (acc_n != hbip_pkg::MagicWord);
          res.err   = hbip_pkg::ERR_BAD_MAGIC;
          res.last  = 1'b1;
        end
        hbip_pkg::ST_VERSION:   res.kind = hbip_pkg::KIND_VERSION;
        hbip_pkg::ST_INT_COUNT: res.kind = hbip_pkg::KIND_INT_COUNT;
        hbip_pkg::ST_STR_COUNT: res.kind = hbip_pkg::KIND_STR_COUNT;
        hbip_pkg::ST_FN_COUNT:  res.kind = hbip_pkg::KIND_FN_COUNT;
        hbip_pkg::ST_INT: begin
          res.kind  = hbip_pkg::KIND_INT;
          res.entry = pool_pos_eff;
        end
        hbip_pkg::ST_STR_BYTE: begin
          res.kind  = hbip_pkg::KIND_STR_BYTE;
          res.entry = pool_pos_eff;
        end
        hbip_pkg::ST_ARGS: begin
          res.kind  = hbip_pkg::KIND_ARGS;
          res.entry = fn_pos_eff;
          res.func  = fn_pos_eff;
        end
        hbip_pkg::ST_VARS: begin
          res.kind  = hbip_pkg::KIND_VARS;
          res.entry = fn_pos_eff;
          res.func  = fn_pos_eff;
        end
        hbip_pkg::ST_CODE_LEN: begin
          res.kind  = hbip_pkg::KIND_CODE_LEN;
          res.entry = fn_pos_eff;
          res.func  = fn_pos_eff;
        end
        hbip_pkg::ST_CODE_BYTE: begin
          res.kind  = hbip_pkg::KIND_CODE_BYTE;
          res.entry = pool_pos_eff;
          res.func  = fn_pos_eff;
        end
        hbip_pkg::ST_NAT_COUNT: begin
          res.kind = hbip_pkg::KIND_NAT_COUNT;
          res.last = (v16 == 16'd0);
        end
        hbip_pkg::ST_NAT_ARGS: begin
          res.kind  = hbip_pkg::KIND_NAT_ARGS;
          res.entry = pool_pos_eff;
        end
        hbip_pkg::ST_NAT_INDEX: begin
          res.kind  = hbip_pkg::KIND_NAT_INDEX;
          res.entry = pool_pos_eff;
          res.last  = (pool_rem_dec == 16'd0);
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= hbip_pkg::ST_MAGIC;
      bif_q       <= 2'd0;
      acc_q       <= 32'd0;
      pool_rem_q  <= 16'd0;
      pool_pos_q  <= 16'd0;
      fn_rem_q    <= 16'd0;
      fn_pos_q    <= 16'd0;
      code_rem_q  <= 16'd0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      stage_q     <= stage_d;
      bif_q       <= bif_d;
      acc_q       <= acc_d;
      pool_rem_q  <= pool_rem_d;
      pool_pos_q  <= pool_pos_d;
      fn_rem_q    <= fn_rem_d;
      fn_pos_q    <= fn_pos_d;
      code_rem_q  <= code_rem_d;
      halted_q    <= halted_d;
      out_valid_q <= res_valid || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `HBIP_ASSERT_NXT(a_last_halts, res_valid && res.last, halted_q,
                   "parser still running after a final result")
  `HBIP_ASSERT_IMP(a_error_is_last, out_valid_q && out_q.kind == hbip_pkg::KIND_ERROR,
                   out_q.last && out_q.err != hbip_pkg::ERR_NONE,
                   "error result without last flag or code")

endmodule

[rtl/hex_bytecode_image_parser.sv]
// hex bytecode image parser, top level
// depends on hbip_pkg, hbip_front, hbip_fifo and hbip_back
//
// takes one text character per request and decodes a hex text image of a
// bytecode file: white space and '#' comments are skipped, hex digit pairs
// form bytes, and the bytes are assembled into the big-endian fields of the
// image (magic, version, int pool, string pool, functions with their code,
// native pool); every field after the magic comes out as one result with its
// kind, value and indexes. the block sustains one character per clock while
// the output takes results: the lexer and the field assembler each handle
// one item per cycle, and a token queue of FifoDepth entries between them
// lets either side stall alone. a field's result is registered in the output
// register, behind the queue. hex errors, end of file in the wrong place and a
// wrong magic give an error result with tlast set; after that, or after the
// last field, characters give no result until one arrives with the start
// flag in tuser, which restarts the parser before that character
module hex_bytecode_image_parser #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // end_of_file
  input  logic [0:0]  s_axis_tuser,   // [0] start_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] field_value, [47:32] entry_index,
                                      // [63:48] function_number, [66:64] error_code,
                                      // [71:67] zero
  output logic        m_axis_tlast,   // last_field
  output logic [3:0]  m_axis_tuser    // [3:0] field_kind
);

  hbip_pkg::token_t  push_token, pop_token;
  hbip_pkg::result_t result;
  logic in_accept, fifo_full, fifo_empty, fifo_pop;

  // every accepted character leaves one token, even a skipped one, so that
  // a restart always reaches the assembler
  assign s_axis_tready = !fifo_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  hbip_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .char_code_i     (s_axis_tdata),
    .end_of_file_i   (s_axis_tlast),
    .start_of_file_i (s_axis_tuser[0]),
    .token_o         (push_token)
  );

  hbip_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  (push_token),
    .pop_i   (fifo_pop),
    .data_o  (pop_token),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  // assembler pops only while its output register is free or draining
  hbip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .token_i     (pop_token),
    .empty_i     (fifo_empty),
    .pop_o       (fifo_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  assign m_axis_tdata = {5'd0, result.err, result.func, result.entry, result.value};
  assign m_axis_tlast = result.last;
  assign m_axis_tuser = result.kind;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// self-checking bench for hex_bytecode_image_parser: random hex text images,
// good and broken, go in one character per request, decoded fields are checked
// against a decoder kept inside the bench; depends on hbip_pkg and the parser rtl
module tb_top;
  import hbip_pkg::*;

  localparam int unsigned NumItems = 1350;
  localparam logic [4:0]  NotHex   = 5'h10;

  // image flavors for the random part
  typedef enum {
    IMG_GOOD,
    IMG_CUT,
    IMG_EOF_DIGIT,
    IMG_BAD_SECOND,
    IMG_BAD_HEX,
    IMG_BAD_MAGIC,
    IMG_ABANDON
  } img_mode_e;

  // one character request with its pre-gap and an optional drain hold-off
  typedef struct {
    logic [7:0]  ch;
    logic        eof;
    logic        sof;
    int unsigned gap;
    bit          drain;
  } char_req_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [3:0]  m_axis_tuser;

  always #4 clk_i = ~clk_i;

  hex_bytecode_image_parser i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // bench-side decoder: lexer phase, layout position and pool counters
  // ---------------------------------------------------------------------------
  phase_e      lex_phase;
  logic [3:0]  first_nib;
  stage_e      fmt_stage;
  logic [1:0]  field_byte;
  logic [31:0] field_acc;
  logic [15:0] pool_left, pool_pos, fn_left, fn_pos, code_left;
  logic        parse_halted;
  result_t     pending_fields[$];   // decoded fields not yet seen on the output
  int unsigned mismatch_cnt = 0;

  task automatic restart_decoder();
    lex_phase    = PH_BETWEEN;
    first_nib    = '0;
    fmt_stage    = ST_MAGIC;
    field_byte   = '0;
    field_acc    = '0;
    pool_left    = '0;
    pool_pos     = '0;
    fn_left      = '0;
    fn_pos       = '0;
    code_left    = '0;
    parse_halted = 1'b0;
  endtask

  task automatic expect_field(input kind_e kind, input logic [31:0] value,
                              input logic [15:0] entry, input logic [15:0] func,
                              input err_e err, input logic last);
    result_t r;
    r.kind  = kind;
    r.value = value;
    r.entry = entry;
    r.func  = func;
    r.err   = err;
    r.last  = last;
    pending_fields.push_back(r);
  endtask

  // every error ends the image and halts the parser until a start request
  task automatic expect_error(input err_e err, input logic [31:0] value);
    parse_halted = 1'b1;
    expect_field(KIND_ERROR, value, '0, '0, err, 1'b1);
  endtask

  function automatic int field_len(stage_e stg);
    case (stg)
      ST_MAGIC, ST_INT:          return 4;
      ST_STR_BYTE, ST_CODE_BYTE: return 1;
      default:                   return 2;
    endcase
  endfunction

  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    return NotHex;
  endfunction

  // space plus tab, newline, vertical tab, form feed, carriage return
  function automatic bit is_blank(logic [7:0] c);
    return c == CharSpace || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // after the last code byte of a function go to the next one or the natives
  task automatic next_function();
    fn_pos    = fn_pos + 16'd1;
    fn_left   = fn_left - 16'd1;
    fmt_stage = (fn_left == '0) ? ST_NAT_COUNT : ST_ARGS;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    stage_e      cur;
    logic [31:0] val;
    logic [15:0] v16, idx, fn;
    cur       = fmt_stage;
    field_acc = {field_acc[23:0], b};
    if (int'(field_byte) + 1 < field_len(cur)) begin
      field_byte = field_byte + 2'd1;
      return;
    end
    field_byte = '0;
    val        = field_acc;
    field_acc  = '0;
    v16        = val[15:0];
    case (cur)
      ST_MAGIC: begin
        if (val != MagicWord) expect_error(ERR_BAD_MAGIC, val);
        else fmt_stage = ST_VERSION;
      end
      ST_VERSION: begin
        fmt_stage = ST_INT_COUNT;
        expect_field(KIND_VERSION, val, '0, '0, ERR_NONE, 1'b0);
      end
      ST_INT_COUNT: begin
        pool_left = v16;
        pool_pos  = '0;
        fmt_stage = (v16 == '0) ? ST_STR_COUNT : ST_INT;
        expect_field(KIND_INT_COUNT, val, '0, '0, ERR_NONE, 1'b0);
      end
      ST_INT: begin
        idx       = pool_pos;
        pool_pos  = pool_pos + 16'd1;
        pool_left = pool_left - 16'd1;
        if (pool_left == '0) fmt_stage = ST_STR_COUNT;
        expect_field(KIND_INT, val, idx, '0, ERR_NONE, 1'b0);
      end
      ST_STR_COUNT: begin
        pool_left = v16;
        pool_pos  = '0;
        fmt_stage = (v16 == '0) ? ST_FN_COUNT : ST_STR_BYTE;
        expect_field(KIND_STR_COUNT, val, '0, '0, ERR_NONE, 1'b0);
      end
      ST_STR_BYTE: begin
        idx       = pool_pos;
        pool_pos  = pool_pos + 16'd1;
        pool_left = pool_left - 16'd1;
        if (pool_left == '0) fmt_stage = ST_FN_COUNT;
        expect_field(KIND_STR_BYTE, val, idx, '0, ERR_NONE, 1'b0);
      end
      ST_FN_COUNT: begin
        fn_left   = v16;
        fn_pos    = '0;
        fmt_stage = (v16 == '0) ? ST_NAT_COUNT : ST_ARGS;
        expect_field(KIND_FN_COUNT, val, '0, '0, ERR_NONE, 1'b0);
      end
      ST_ARGS: begin
        fmt_stage = ST_VARS;
        expect_field(KIND_ARGS, val, fn_pos, fn_pos, ERR_NONE, 1'b0);
      end
      ST_VARS: begin
        fmt_stage = ST_CODE_LEN;
        expect_field(KIND_VARS, val, fn_pos, fn_pos, ERR_NONE, 1'b0);
      end
      ST_CODE_LEN: begin
        idx       = fn_pos;
        code_left = v16;
        pool_pos  = '0;
        // an empty code body closes the function right away
        if (v16 == '0) next_function();
        else fmt_stage = ST_CODE_BYTE;
        expect_field(KIND_CODE_LEN, val, idx, idx, ERR_NONE, 1'b0);
      end
      ST_CODE_BYTE: begin
        idx       = pool_pos;
        fn        = fn_pos;
        pool_pos  = pool_pos + 16'd1;
        code_left = code_left - 16'd1;
        if (code_left == '0) next_function();
        expect_field(KIND_CODE_BYTE, val, idx, fn, ERR_NONE, 1'b0);
      end
      ST_NAT_COUNT: begin
        pool_left    = v16;
        pool_pos     = '0;
        parse_halted = (v16 == '0);
        if (v16 != '0) fmt_stage = ST_NAT_ARGS;
        expect_field(KIND_NAT_COUNT, val, '0, '0, ERR_NONE, v16 == '0);
      end
      ST_NAT_ARGS: begin
        fmt_stage = ST_NAT_INDEX;
        expect_field(KIND_NAT_ARGS, val, pool_pos, '0, ERR_NONE, 1'b0);
      end
      ST_NAT_INDEX: begin
        idx          = pool_pos;
        pool_pos     = pool_pos + 16'd1;
        pool_left    = pool_left - 16'd1;
        parse_halted = (pool_left == '0);
        fmt_stage    = ST_NAT_ARGS;
        expect_field(KIND_NAT_INDEX, val, idx, '0, ERR_NONE, pool_left == '0);
      end
      default: parse_halted = 1'b1;
    endcase
  endtask

  // one accepted character request through lexer and field assembly
  task automatic decode_char(input logic [7:0] c, input logic eof, input logic sof);
    logic [4:0] nib;
    if (sof) restart_decoder();
    if (parse_halted) return;
    if (eof) begin
      if (lex_phase == PH_HIGH) expect_error(ERR_EOF_DIGIT, '0);
      else expect_error(ERR_PREMATURE, '0);
      return;
    end
    if (lex_phase == PH_COMMENT) begin
      if (c == CharNewline) lex_phase = PH_BETWEEN;
      return;
    end
    nib = hex_nibble(c);
    // a second digit must follow the first one directly
    if (lex_phase == PH_HIGH) begin
      lex_phase = PH_BETWEEN;
      if (nib == NotHex) expect_error(ERR_BAD_SECOND, '0);
      else absorb_byte({first_nib, nib[3:0]});
      return;
    end
    lex_phase = PH_BETWEEN;
    if (c == CharHash) begin
      lex_phase = PH_COMMENT;
    end else if (!is_blank(c)) begin
      if (nib == NotHex) begin
        expect_error(ERR_BAD_HEX, '0);
      end else begin
        first_nib = nib[3:0];
        lex_phase = PH_HIGH;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // text image generation
  // ---------------------------------------------------------------------------
  char_req_t   char_queue[$];
  logic [7:0]  image_bytes[$];
  bit          sof_next   = 1'b0;
  bit          drain_next = 1'b0;
  bit          tx_quiet   = 1'b0;
  int unsigned items_made = 0;

  task automatic push_char(input logic [7:0] ch, input logic eof);
    char_req_t r;
    r.ch       = ch;
    r.eof      = eof;
    r.sof      = sof_next;
    r.drain    = drain_next;
    r.gap      = tx_quiet ? 0 : $urandom_range(0, 3);
    sof_next   = 1'b0;
    drain_next = 1'b0;
    char_queue.push_back(r);
    items_made++;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] base;
    if (nib < 4'd10) return "0" + {4'd0, nib};
    base = ($urandom_range(0, 1) != 0) ? "a" : "A";
    return base + {4'd0, nib} - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 0) ? CharSpace : 8'h08 + 8'(r);
  endfunction

  function automatic logic [7:0] comment_char();
    logic [7:0] c;
    c = 8'($urandom);
    while (c == CharNewline) c = 8'($urandom);
    return c;
  endfunction

  // a character that is no hex digit; sep_ok lets blanks and '#' through
  function automatic logic [7:0] bad_char(input bit sep_ok);
    logic [7:0] c;
    c = 8'($urandom);
    while (hex_nibble(c) != NotHex || (!sep_ok && (is_blank(c) || c == CharHash)))
      c = 8'($urandom);
    return c;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned small_count(input int unsigned hi);
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, hi);
  endfunction

  task automatic push_hex(input logic [7:0] b);
    push_char(hex_char(b[7:4]), 1'b0);
    push_char(hex_char(b[3:0]), 1'b0);
  endtask

  // white space, a comment line, or nothing between two bytes
  task automatic push_separator();
    case ($urandom_range(0, 9))
      0, 1, 2: repeat ($urandom_range(1, 3)) push_char(blank_char(), 1'b0);
      3: begin
        push_char(CharHash, 1'b0);
        repeat ($urandom_range(0, 5)) push_char(comment_char(), 1'b0);
        push_char(CharNewline, 1'b0);
      end
      default: begin
      end
    endcase
  endtask

  task automatic push_be(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) image_bytes.push_back(v[8*i +: 8]);
  endtask

  // a well-formed byte image with small pools and random content
  task automatic build_image();
    int unsigned n_int, n_str, n_fn, n_code, n_nat;
    image_bytes.delete();
    push_be(MagicWord, 4);
    push_be(pick_value(), 2);
    n_int = small_count(3);
    push_be(n_int, 2);
    repeat (n_int) push_be(pick_value(), 4);
    n_str = small_count(4);
    push_be(n_str, 2);
    repeat (n_str) push_be(pick_value(), 1);
    n_fn = small_count(3);
    push_be(n_fn, 2);
    repeat (n_fn) begin
      push_be(pick_value(), 2);
      push_be(pick_value(), 2);
      n_code = small_count(4);
      push_be(n_code, 2);
      repeat (n_code) push_be(pick_value(), 1);
    end
    n_nat = small_count(3);
    push_be(n_nat, 2);
    repeat (n_nat) begin
      push_be(pick_value(), 2);
      push_be(pick_value(), 2);
    end
  endtask

  task automatic send_image(input img_mode_e mode);
    int unsigned stop_at, k;
    build_image();
    stop_at = image_bytes.size();
    if (mode == IMG_BAD_MAGIC) begin
      k              = $urandom_range(0, 3);
      image_bytes[k] = image_bytes[k] ^ 8'($urandom_range(1, 255));
      stop_at        = 4 + $urandom_range(0, 3);
    end else if (mode != IMG_GOOD) begin
      stop_at = $urandom_range(0, image_bytes.size() - 1);
    end
    sof_next = 1'b1;
    for (int unsigned i = 0; i < stop_at; i++) begin
      push_separator();
      push_hex(image_bytes[i]);
    end
    case (mode)
      IMG_CUT: begin
        // end of file between bytes, sometimes inside an open comment
        if ($urandom_range(0, 1) != 0) begin
          push_char(CharHash, 1'b0);
          repeat ($urandom_range(0, 3)) push_char(comment_char(), 1'b0);
        end
        push_char(8'($urandom), 1'b1);
      end
      IMG_EOF_DIGIT: begin
        push_char(hex_char(4'($urandom)), 1'b0);
        push_char(8'($urandom), 1'b1);
      end
      IMG_BAD_SECOND: begin
        push_char(hex_char(4'($urandom)), 1'b0);
        push_char(bad_char(1'b1), 1'b0);
      end
      IMG_BAD_HEX: begin
        push_separator();
        push_char(bad_char(1'b0), 1'b0);
      end
      IMG_GOOD, IMG_BAD_MAGIC: begin
        // trailing junk and end of file are ignored once halted
        repeat ($urandom_range(0, 2)) push_char(8'($urandom), 1'b0);
        if ($urandom_range(0, 1) != 0) push_char(8'($urandom), 1'b1);
      end
      default: begin
        // abandoned image: the next start request restarts mid-stream
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // request driver, result receiver and monitor
  // ---------------------------------------------------------------------------
  char_req_t   cur_req;
  bit          cur_loaded = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  bit          rx_quiet   = 1'b0;
  logic        req_taken  = 1'b0;
  logic        res_taken  = 1'b0;

  // holds a request until taken, then waits its gap (and a drain if marked)
  always @(negedge clk_i) begin
    logic drive_vld;
    if (rst_ni) begin
      drive_vld = s_axis_tvalid && !req_taken;
      if (!drive_vld) begin
        if (!cur_loaded && char_queue.size() != 0) begin
          cur_req    = char_queue.pop_front();
          cur_loaded = 1'b1;
          gap_left   = cur_req.gap;
        end
        if (cur_loaded && (!cur_req.drain || pending_fields.size() == 0)) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            drive_vld     = 1'b1;
            cur_loaded    = 1'b0;
            s_axis_tdata <= cur_req.ch;
            s_axis_tlast <= cur_req.eof;
            s_axis_tuser <= cur_req.sof;
          end
        end
      end
      s_axis_tvalid <= drive_vld;
    end
  end

  // result side drops ready for a random stall after each result, but for quiet stretches
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        stall_left = rx_quiet ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void note_failure(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  // check the output first, then feed the accepted request to the decoder
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      res_taken <= m_axis_tvalid && m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_fields.size() == 0) begin
          note_failure($sformatf("unexpected result kind %0d value %h",
                                 m_axis_tuser, m_axis_tdata[31:0]));
        end else begin
          want = pending_fields.pop_front();
          if (m_axis_tuser !== want.kind || m_axis_tdata[31:0] !== want.value ||
              m_axis_tdata[47:32] !== want.entry || m_axis_tdata[63:48] !== want.func ||
              m_axis_tdata[66:64] !== want.err || m_axis_tlast !== want.last ||
              m_axis_tdata[71:67] !== '0)
            note_failure($sformatf(
              "exp kind %0d val %h ent %0d fn %0d err %0d last %b / got %0d %h %0d %0d %0d %b pad %h",
              want.kind, want.value, want.entry, want.func, want.err, want.last,
              m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tdata[63:48],
              m_axis_tdata[66:64], m_axis_tlast, m_axis_tdata[71:67]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        decode_char(s_axis_tdata, s_axis_tlast, s_axis_tuser[0]);
    end
  end

  // ---------------------------------------------------------------------------
  // reset, stimulus, end of run
  // ---------------------------------------------------------------------------
  initial begin : reset_seq
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    img_mode_e mode;
    restart_decoder();

    // start together with end of file, then end of file while halted
    sof_next = 1'b1;
    push_char(8'hFF, 1'b1);
    push_char(8'h00, 1'b1);
    // bad first character
    sof_next = 1'b1;
    push_char("G", 1'b0);
    // white space as second digit
    sof_next = 1'b1;
    push_char("a", 1'b0);
    push_char(CharSpace, 1'b0);
    // end of file after one digit, sender waits for earlier results first
    drain_next = 1'b1;
    sof_next   = 1'b1;
    push_char("F", 1'b0);
    push_char(8'h5A, 1'b1);
    // end of file inside a comment
    sof_next = 1'b1;
    push_char(CharHash, 1'b0);
    push_char(8'h80, 1'b0);
    push_char(8'h7F, 1'b1);
    // magic off by one bit
    sof_next = 1'b1;
    push_hex(8'hC0);
    push_hex(8'hC0);
    push_hex(8'hFF);
    push_hex(8'hEF);
    // '#' as second digit
    sof_next = 1'b1;
    push_char("9", 1'b0);
    push_char(CharHash, 1'b0);

    // random images, about half of them well formed
    items_made = 0;
    while (items_made < NumItems) begin
      if ($urandom_range(0, 3) == 0) tx_quiet = !tx_quiet;
      if ($urandom_range(0, 7) == 0) drain_next = 1'b1;
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4, 5: mode = IMG_GOOD;
        6:                mode = IMG_CUT;
        7:                mode = IMG_EOF_DIGIT;
        8:                mode = IMG_BAD_SECOND;
        9:                mode = IMG_BAD_HEX;
        10:               mode = IMG_BAD_MAGIC;
        default:          mode = IMG_ABANDON;
      endcase
      send_image(mode);
    end

    while (char_queue.size() != 0 || cur_loaded || s_axis_tvalid) @(posedge clk_i);
    while (pending_fields.size() != 0) @(posedge clk_i);
    // catch stray results still inside the pipeline
    repeat (32) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
